>>> rtl/dtc_status_byte_manager_assert.svh
// ---------------------------------------------------------------------------
// dtc_status_byte_manager_assert.svh
// Assertion macros used by the status byte manager checker.
// ---------------------------------------------------------------------------
`ifndef DTC_STATUS_BYTE_MANAGER_ASSERT_SVH
`define DTC_STATUS_BYTE_MANAGER_ASSERT_SVH

// same-cycle implication
`define DSBM_ASSERT_NOW(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("dsbm check failed");

// next-cycle implication
`define DSBM_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("dsbm check failed");

`endif

>>> rtl/dsbm_pkg.sv
// ---------------------------------------------------------------------------
// dsbm_pkg
// Types and constants of the DTC status byte manager.
// ---------------------------------------------------------------------------
package dsbm_pkg;

	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 8;

	localparam logic [CFG_IDX_W-1:0] CFG_MIL_MASK     = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_OBD_RST_MASK = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_CLR_BIT5     = 2'd2;

	localparam logic [2:0] CMD_DEBOUNCE    = 3'd0;
	localparam logic [2:0] CMD_OBD         = 3'd1;
	localparam logic [2:0] CMD_THRESHOLD   = 3'd2;
	localparam logic [2:0] CMD_CLEAR       = 3'd3;
	localparam logic [2:0] CMD_POWER_RESET = 3'd4;
	localparam logic [2:0] CMD_CYCLE_START = 3'd5;
	localparam logic [2:0] CMD_RESET_ALL   = 3'd6;
	localparam logic [2:0] CMD_OBD_RESET   = 3'd7;

	localparam logic [2:0] DEB_PRESENT  = 3'd0;
	localparam logic [2:0] DEB_FUGITIVE = 3'd1;
	localparam logic [2:0] DEB_INVALID  = 3'd6;

	localparam logic [2:0] OBD_OK          = 3'd0;
	localparam logic [2:0] OBD_CONFIRMED   = 3'd1;
	localparam logic [2:0] OBD_PENDING2    = 3'd2;
	localparam logic [2:0] OBD_HISTORY_ON  = 3'd3;
	localparam logic [2:0] OBD_HISTORY_OFF = 3'd4;
	localparam logic [2:0] OBD_INVALID     = 3'd6;

	localparam logic [1:0] NOTIFY_NONE    = 2'd0;
	localparam logic [1:0] NOTIFY_UPDATED = 2'd1;
	localparam logic [1:0] NOTIFY_REINIT  = 2'd2;
	localparam logic [1:0] NOTIFY_ALL_RST = 2'd3;

	localparam logic [7:0] STATUS_INIT = 8'h50;

	typedef struct packed {
		logic [2:0] command;
		logic [2:0] dtc_index;
		logic [2:0] debounce_state;
		logic [2:0] obd_state;
	} in_t;

	typedef struct packed {
		logic [2:0] entry_index;
		logic [7:0] status_byte;
		logic [1:0] notify_code;
		logic       invalid_state;
		logic       last;
	} out_t;

	typedef struct packed {
		logic load;
		logic rd;
		logic mod;
		logic adv;
	} dsbm_cmd_t;

	typedef struct packed {
		logic emit;
		logic done;
	} dsbm_sts_t;

endpackage

>>> rtl/dsbm_ram.sv
// ---------------------------------------------------------------------------
// dsbm_ram
// Generic single-write, single-read RAM with registered read data.
// ---------------------------------------------------------------------------
module dsbm_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 8,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic             re,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

>>> rtl/dsbm_ctrl.sv
// ---------------------------------------------------------------------------
// dsbm_ctrl
// Sequencer: request intake, read-modify-write per entry, result handoff.
// ---------------------------------------------------------------------------
module dsbm_ctrl
	import dsbm_pkg::*;
(
	input  logic      clk,
	input  logic      arst_n,
	input  logic      in_valid,
	output logic      in_ready,
	output logic      out_valid,
	input  logic      out_ready,
	output dsbm_cmd_t cmd,
	input  dsbm_sts_t sts
);

	localparam logic [1:0] S_IDLE = 2'd0;
	localparam logic [1:0] S_RD   = 2'd1;
	localparam logic [1:0] S_MOD  = 2'd2;
	localparam logic [1:0] S_OUT  = 2'd3;

	logic [1:0] state_q;
	logic [1:0] state_nxt;

	always_comb begin
		state_nxt = state_q;
		cmd       = '0;
		case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					cmd.load  = 1'b1;
					state_nxt = S_RD;
				end
			end
			S_RD: begin
				cmd.rd    = 1'b1;
				state_nxt = S_MOD;
			end
			S_MOD: begin
				cmd.mod = 1'b1;
				if (sts.emit) begin
					state_nxt = S_OUT;
				end else if (sts.done) begin
					state_nxt = S_IDLE;
				end else begin
					cmd.adv   = 1'b1;
					state_nxt = S_RD;
				end
			end
			S_OUT: begin
				if (out_ready) begin
					if (sts.done) begin
						state_nxt = S_IDLE;
					end else begin
						cmd.adv   = 1'b1;
						state_nxt = S_RD;
					end
				end
			end
			default: begin
				state_nxt = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_nxt;
		end
	end

	assign in_ready  = (state_q == S_IDLE);
	assign out_valid = (state_q == S_OUT);

endmodule

>>> rtl/dsbm_dp.sv
// ---------------------------------------------------------------------------
// dsbm_dp
// Datapath: config registers, status table, entry update and result register.
// ---------------------------------------------------------------------------
module dsbm_dp
	import dsbm_pkg::*;
#(
	parameter int DTC_COUNT = 8
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data,
	input  in_t                   in_data,
	output out_t                  out_data,
	input  dsbm_cmd_t             cmd,
	output dsbm_sts_t             sts
);

	localparam int AW    = (DTC_COUNT > 1) ? $clog2(DTC_COUNT) : 1;
	localparam int PTR_W = (AW > 3) ? AW : 3;
	localparam int NRPT  = (DTC_COUNT < 8) ? DTC_COUNT : 8;
	localparam logic [2:0]     LAST_RPT = 3'(NRPT - 1);
	localparam logic [PTR_W:0] COUNT_X  = (PTR_W+1)'(DTC_COUNT);
	localparam logic [PTR_W:0] RPT_X    = (PTR_W+1)'(8);
	localparam logic [PTR_W-1:0] PTR_END = PTR_W'(DTC_COUNT - 1);

	logic [7:0]           mil_mask_q;
	logic [7:0]           rst_mask_q;
	logic                 clr5_q;
	logic [DTC_COUNT-1:0] vld_q;

	in_t              req_q;
	logic             sweep_q;
	logic [PTR_W-1:0] ptr_q;
	logic [2:0]       last_idx_q;
	logic             rd_vld_s1;
	out_t             out_q;

	logic [AW-1:0] addr;
	logic [7:0]    ram_rdata;
	logic [7:0]    cur;
	logic [7:0]    nb;
	logic [1:0]    notify;
	logic          inval;
	logic          touched;
	logic          in_range;
	logic          rpt;
	logic          mil_bit;
	logic          rst_bit;
	logic          wr_en;
	logic [2:0]    obd_last;

	// configuration
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mil_mask_q <= '0;
			rst_mask_q <= '0;
			clr5_q     <= 1'b0;
		end else if (cfg_we) begin
			case (cfg_index)
				CFG_MIL_MASK:     mil_mask_q <= cfg_data;
				CFG_OBD_RST_MASK: rst_mask_q <= cfg_data;
				CFG_CLR_BIT5:     clr5_q     <= cfg_data[0];
				default: begin
				end
			endcase
		end
	end

	// highest reported entry of the obd reset sweep
	always_comb begin
		obd_last = '0;
		for (int j = 0; j < 8; j++) begin
			if (j < NRPT && rst_mask_q[j]) begin
				obd_last = 3'(j);
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sweep_q <= 1'b0;
			ptr_q   <= '0;
		end else if (cmd.load) begin
			sweep_q <= (in_data.command >= CMD_CYCLE_START);
			ptr_q   <= (in_data.command >= CMD_CYCLE_START) ? '0 : PTR_W'(in_data.dtc_index);
		end else if (cmd.adv) begin
			ptr_q <= ptr_q + PTR_W'(1);
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			req_q      <= in_data;
			last_idx_q <= (in_data.command == CMD_OBD_RESET) ? obd_last : LAST_RPT;
		end
	end

	assign addr     = ptr_q[AW-1:0];
	assign in_range = ({1'b0, ptr_q} < COUNT_X);
	assign rpt      = ({1'b0, ptr_q} < RPT_X);
	assign mil_bit  = rpt && mil_mask_q[ptr_q[2:0]];
	assign rst_bit  = rpt && rst_mask_q[ptr_q[2:0]];

	dsbm_ram #(
		.WIDTH (8),
		.DEPTH (DTC_COUNT)
	) u_ram (
		.clk   (clk),
		.we    (wr_en),
		.waddr (addr),
		.wdata (nb),
		.re    (cmd.rd),
		.raddr (addr),
		.rdata (ram_rdata)
	);

	// entries never written since reset read as the init value
	always_ff @(posedge clk) begin
		if (cmd.rd) begin
			rd_vld_s1 <= in_range && vld_q[addr];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else if (wr_en) begin
			vld_q[addr] <= 1'b1;
		end
	end

	assign cur = rd_vld_s1 ? ram_rdata : STATUS_INIT;

	always_comb begin
		nb      = cur;
		notify  = NOTIFY_NONE;
		inval   = 1'b0;
		touched = in_range;
		case (req_q.command)
			CMD_DEBOUNCE: begin
				if (req_q.debounce_state == DEB_PRESENT) begin
					nb     = cur | 8'h27;
					notify = NOTIFY_UPDATED;
				end else if (req_q.debounce_state == DEB_FUGITIVE) begin
					nb     = cur & 8'hFE;
					notify = NOTIFY_UPDATED;
				end else if (req_q.debounce_state >= DEB_INVALID) begin
					inval = 1'b1;
				end
			end
			CMD_OBD: begin
				if (req_q.obd_state == OBD_OK) begin
					nb     = cur & 8'hF3;
					notify = NOTIFY_UPDATED;
				end else if (req_q.obd_state == OBD_CONFIRMED ||
				             req_q.obd_state == OBD_PENDING2) begin
					nb     = cur | 8'h08 | {mil_bit, 7'd0};
					notify = NOTIFY_UPDATED;
				end else if (req_q.obd_state == OBD_HISTORY_ON) begin
					nb     = cur & 8'hFB;
					notify = NOTIFY_UPDATED;
				end else if (req_q.obd_state == OBD_HISTORY_OFF) begin
					nb     = cur & 8'hFB & {~mil_bit, 7'h7F};
					notify = NOTIFY_UPDATED;
				end else if (req_q.obd_state >= OBD_INVALID) begin
					inval = 1'b1;
				end
			end
			CMD_THRESHOLD: begin
				nb     = (cur & 8'hAF) | {6'd0, (req_q.debounce_state == DEB_PRESENT), 1'b0};
				notify = NOTIFY_UPDATED;
			end
			CMD_CLEAR: begin
				nb = clr5_q ? (cur & 8'hDF) : cur;
			end
			CMD_POWER_RESET: begin
				if (req_q.debounce_state == DEB_FUGITIVE) begin
					nb = nb & 8'hFE;
				end
				if (req_q.obd_state == OBD_HISTORY_OFF) begin
					nb = nb & 8'hFB & {~mil_bit, 7'h7F};
				end
			end
			CMD_CYCLE_START: begin
				nb      = (cur | 8'h40) & 8'hFD;
				notify  = NOTIFY_REINIT;
				touched = 1'b1;
			end
			CMD_RESET_ALL: begin
				nb      = STATUS_INIT;
				notify  = NOTIFY_ALL_RST;
				touched = 1'b1;
			end
			CMD_OBD_RESET: begin
				nb      = STATUS_INIT;
				notify  = NOTIFY_REINIT;
				touched = rst_bit;
			end
			default: begin
				nb = cur;
			end
		endcase
	end

	assign wr_en    = cmd.mod && touched;
	assign sts.emit = sweep_q ? (touched && rpt) : 1'b1;
	assign sts.done = !sweep_q || (ptr_q == PTR_END);

	always_ff @(posedge clk) begin
		if (cmd.mod && sts.emit) begin
			out_q.entry_index   <= ptr_q[2:0];
			out_q.status_byte   <= in_range ? nb : 8'd0;
			out_q.notify_code   <= in_range ? notify : NOTIFY_NONE;
			out_q.invalid_state <= in_range && inval;
			out_q.last          <= sweep_q ? (ptr_q[2:0] == last_idx_q) : 1'b1;
		end
	end

	assign out_data = out_q;

endmodule

>>> rtl/dtc_status_byte_manager.sv
// ---------------------------------------------------------------------------
// dtc_status_byte_manager
// Per-entry DTC status bytes updated by debounce, OBD and sweep requests.
// ---------------------------------------------------------------------------
// One request is handled at a time. The block takes a request while idle,
// then every visited entry passes through a read state and a modify/write
// state on the status RAM, and every result then waits in the output
// register until it is taken. A sweep reports at most 8 results. Entries not
// yet written since reset read as 0x50 through per-entry valid flops, so no
// clearing pass runs after reset. Results appear in entry order with last
// set on the final one; an obd reset with an empty mask returns none.
// ---------------------------------------------------------------------------
module dtc_status_byte_manager
	import dsbm_pkg::*;
#(
	parameter int DTC_COUNT = 8
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  in_valid,
	output logic                  in_ready,
	input  in_t                   in_data,
	output logic                  out_valid,
	input  logic                  out_ready,
	output out_t                  out_data,
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data
);

	dsbm_cmd_t cmd;
	dsbm_sts_t sts;

	dsbm_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.cmd       (cmd),
		.sts       (sts)
	);

	dsbm_dp #(
		.DTC_COUNT (DTC_COUNT)
	) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.in_data   (in_data),
		.out_data  (out_data),
		.cmd       (cmd),
		.sts       (sts)
	);

endmodule

>>> rtl/dsbm_checker.sv
// ---------------------------------------------------------------------------
// dsbm_checker
// Port-level checks of the status byte manager, bound to the top level.
// ---------------------------------------------------------------------------
`include "dtc_status_byte_manager_assert.svh"

module dsbm_checker
	import dsbm_pkg::*;
(
	input logic clk,
	input logic arst_n,
	input logic in_valid,
	input logic in_ready,
	input logic out_valid,
	input logic out_ready,
	input out_t out_data
);

	// no new request while a result is pending
	`DSBM_ASSERT_NOW(a_idle_no_result, clk, arst_n, in_ready, !out_valid)

	// a taken request keeps the block busy next cycle
	`DSBM_ASSERT_NEXT(a_busy_after_req, clk, arst_n, in_valid && in_ready, !in_ready)

	// nothing follows the final result at once
	`DSBM_ASSERT_NEXT(a_last_ends, clk, arst_n, out_valid && out_ready && out_data.last, !out_valid)

	// a stalled result holds
	`DSBM_ASSERT_NEXT(a_out_hold, clk, arst_n, out_valid && !out_ready, out_valid && $stable(out_data))

endmodule

bind dtc_status_byte_manager dsbm_checker u_dsbm_checker (.*);

>>> verif/testbench.sv
// ---------------------------------------------------------------------------
// testbench
// Self-checking bench for the DTC status byte manager. A short table of
// directed requests covers each command, the undefined state codes, the MIL
// and OBD reset masks and the bit 5 clear switch, followed by random requests
// under several register settings. Every result is checked field by field
// against an in-bench prediction of the status table, with random stalls on
// both handshakes, one long output stall and one full drain mid-run.
// ---------------------------------------------------------------------------
module testbench;
	import dsbm_pkg::*;

	timeunit 1ns;
	timeprecision 1ps;

	localparam int DTC_COUNT     = 8;
	localparam int SETTLE_CYCLES = 2 * DTC_COUNT + 16;
	localparam int PHASES        = 4;
	localparam int PHASE_ITEMS   = 96;
	localparam int HOLD_AT       = 120;
	localparam int HOLD_CYCLES   = 300;

	// state codes the package leaves unnamed
	localparam logic [2:0] DEB_DEVALIDATION = 3'd2;
	localparam logic [2:0] DEB_PCTL_ABSENT  = 3'd3;
	localparam logic [2:0] DEB_INVALID_HI   = 3'd7;
	localparam logic [2:0] OBD_PENDING1     = 3'd5;
	localparam logic [2:0] OBD_INVALID_HI   = 3'd7;

	typedef struct {
		bit         is_cfg;
		in_t        req;
		logic [7:0] mil;
		logic [7:0] obdm;
		logic       clr;
		bit         typed;
		out_t       want;
	} plan_row_t;

	logic                  clk       = 1'b0;
	logic                  arst_n    = 1'b0;
	logic                  in_valid  = 1'b0;
	logic                  in_ready;
	in_t                   in_data   = '0;
	logic                  out_valid;
	logic                  out_ready = 1'b0;
	out_t                  out_data;
	logic                  cfg_we    = 1'b0;
	logic [CFG_IDX_W-1:0]  cfg_index = '0;
	logic [CFG_DATA_W-1:0] cfg_data  = '0;

	logic [7:0] status_mirror [DTC_COUNT];
	logic [7:0] mil_mask_q   = 8'h00;
	logic [7:0] obd_mask_q   = 8'h00;
	logic       clr5_q       = 1'b0;

	out_t      expected_reports[$];
	plan_row_t directed_plan[$];

	int mismatches    = 0;
	int reports_seen  = 0;
	int requests_sent = 0;
	int sweeps_sent   = 0;
	int settings_used = 0;

	dtc_status_byte_manager #(
		.DTC_COUNT(DTC_COUNT)
	) u_top (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.in_data  (in_data),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.out_data (out_data),
		.cfg_we   (cfg_we),
		.cfg_index(cfg_index),
		.cfg_data (cfg_data)
	);

	always #5 clk = ~clk;

	// status table update and the results one request produces
	task automatic predict_reports(input in_t r);
		logic [7:0] s;
		logic       mil;
		logic       hit;
		bit         pending;
		out_t       rep;
		out_t       held;
		int         i;
		pending = 1'b0;
		held    = '0;
		if (r.command >= CMD_CYCLE_START) begin
			for (i = 0; i < DTC_COUNT; i++) begin
				hit = 1'b1;
				if (r.command == CMD_CYCLE_START)
					status_mirror[i] = (status_mirror[i] | 8'h40) & 8'hFD;
				else if (r.command == CMD_RESET_ALL || obd_mask_q[i])
					status_mirror[i] = STATUS_INIT;
				else
					hit = 1'b0;
				if (hit) begin
					if (pending)
						expected_reports.push_back(held);
					held.entry_index   = 3'(i);
					held.status_byte   = status_mirror[i];
					held.notify_code   = (r.command == CMD_RESET_ALL) ? NOTIFY_ALL_RST :
						NOTIFY_REINIT;
					held.invalid_state = 1'b0;
					held.last          = 1'b0;
					pending            = 1'b1;
				end
			end
			if (pending) begin
				held.last = 1'b1;
				expected_reports.push_back(held);
			end
		end else begin
			s                 = status_mirror[r.dtc_index];
			mil               = mil_mask_q[r.dtc_index];
			rep.notify_code   = NOTIFY_NONE;
			rep.invalid_state = 1'b0;
			case (r.command)
				CMD_DEBOUNCE: begin
					if (r.debounce_state == DEB_PRESENT) begin
						s |= 8'h27;
						rep.notify_code = NOTIFY_UPDATED;
					end else if (r.debounce_state == DEB_FUGITIVE) begin
						s &= 8'hFE;
						rep.notify_code = NOTIFY_UPDATED;
					end else if (r.debounce_state >= DEB_INVALID) begin
						rep.invalid_state = 1'b1;
					end
				end
				CMD_OBD: begin
					case (r.obd_state)
						OBD_OK: s &= 8'hF3;
						OBD_CONFIRMED, OBD_PENDING2: s |= (mil ? 8'h88 : 8'h08);
						OBD_HISTORY_ON: s &= 8'hFB;
						OBD_HISTORY_OFF: s &= (mil ? 8'h7B : 8'hFB);
						default: ;
					endcase
					if (r.obd_state <= OBD_HISTORY_OFF)
						rep.notify_code = NOTIFY_UPDATED;
					else if (r.obd_state >= OBD_INVALID)
						rep.invalid_state = 1'b1;
				end
				CMD_THRESHOLD: begin
					s = (s & 8'hAF) | ((r.debounce_state == DEB_PRESENT) ? 8'h02 : 8'h00);
					rep.notify_code = NOTIFY_UPDATED;
				end
				CMD_CLEAR: begin
					if (clr5_q)
						s &= 8'hDF;
				end
				default: begin
					if (r.debounce_state == DEB_FUGITIVE)
						s &= 8'hFE;
					if (r.obd_state == OBD_HISTORY_OFF)
						s &= (mil ? 8'h7B : 8'hFB);
				end
			endcase
			status_mirror[r.dtc_index] = s;
			rep.entry_index = r.dtc_index;
			rep.status_byte = s;
			rep.last        = 1'b1;
			expected_reports.push_back(rep);
		end
	endtask

	task automatic compare_field(input string name, input logic [7:0] want,
		input logic [7:0] got);
		if (want !== got) begin
			$error("%s mismatch: expected 0x%0h, got 0x%0h", name, want, got);
			mismatches++;
		end
	endtask

	task automatic check_report(input out_t got);
		out_t want;
		if (expected_reports.size() == 0) begin
			$error("unexpected result: entry %0d status 0x%0h", got.entry_index,
				got.status_byte);
			mismatches++;
		end else begin
			want = expected_reports.pop_front();
			compare_field("entry_index", 8'(want.entry_index), 8'(got.entry_index));
			compare_field("status_byte", want.status_byte, got.status_byte);
			compare_field("notify_code", 8'(want.notify_code), 8'(got.notify_code));
			compare_field("invalid_state", 8'(want.invalid_state), 8'(got.invalid_state));
			compare_field("last", 8'(want.last), 8'(got.last));
		end
	endtask

	function automatic void add_req(input logic [2:0] cmd, input logic [2:0] idx,
		input logic [2:0] deb, input logic [2:0] obd);
		plan_row_t row;
		row.is_cfg             = 1'b0;
		row.req.command        = cmd;
		row.req.dtc_index      = idx;
		row.req.debounce_state = deb;
		row.req.obd_state      = obd;
		row.mil                = 8'h00;
		row.obdm               = 8'h00;
		row.clr                = 1'b0;
		row.typed              = 1'b0;
		row.want               = '0;
		directed_plan.push_back(row);
	endfunction

	function automatic void add_checked(input logic [2:0] cmd, input logic [2:0] idx,
		input logic [2:0] deb, input logic [2:0] obd, input logic [7:0] status,
		input logic [1:0] notify, input logic inval);
		plan_row_t row;
		add_req(cmd, idx, deb, obd);
		row = directed_plan.pop_back();
		row.typed              = 1'b1;
		row.want.entry_index   = idx;
		row.want.status_byte   = status;
		row.want.notify_code   = notify;
		row.want.invalid_state = inval;
		row.want.last          = 1'b1;
		directed_plan.push_back(row);
	endfunction

	function automatic void add_cfg(input logic [7:0] mil, input logic [7:0] obdm,
		input logic clr);
		plan_row_t row;
		row.is_cfg = 1'b1;
		row.req    = '0;
		row.mil    = mil;
		row.obdm   = obdm;
		row.clr    = clr;
		row.typed  = 1'b0;
		row.want   = '0;
		directed_plan.push_back(row);
	endfunction

	task automatic drain(input int settle);
		in_valid <= 1'b0;
		do @(posedge clk); while (expected_reports.size() != 0);
		repeat (settle) @(posedge clk);
	endtask

	task automatic program_config(input logic [7:0] mil, input logic [7:0] obdm,
		input logic clr);
		cfg_we    <= 1'b1;
		cfg_index <= CFG_MIL_MASK;
		cfg_data  <= mil;
		@(posedge clk);
		cfg_index <= CFG_OBD_RST_MASK;
		cfg_data  <= obdm;
		@(posedge clk);
		cfg_index <= CFG_CLR_BIT5;
		cfg_data  <= CFG_DATA_W'(clr);
		@(posedge clk);
		cfg_we     <= 1'b0;
		mil_mask_q  = mil;
		obd_mask_q  = obdm;
		clr5_q      = clr;
		settings_used++;
	endtask

	task automatic send_request(input in_t r, input bit burst);
		int gap;
		gap = burst ? 0 : $urandom_range(0, 9);
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_data  <= r;
		in_valid <= 1'b1;
		do @(posedge clk); while (!in_ready);
		predict_reports(r);
		requests_sent++;
		if (r.command >= CMD_CYCLE_START)
			sweeps_sent++;
	endtask

	initial begin : request_source
		in_t req;
		int  ph;
		int  n;
		int  pick;
		bit  burst;
		for (n = 0; n < DTC_COUNT; n++)
			status_mirror[n] = STATUS_INIT;

		add_checked(CMD_DEBOUNCE, 3'd0, DEB_PRESENT, OBD_OK, 8'h77, NOTIFY_UPDATED, 1'b0);
		add_checked(CMD_DEBOUNCE, 3'd7, DEB_FUGITIVE, OBD_OK, 8'h50, NOTIFY_UPDATED, 1'b0);
		add_checked(CMD_DEBOUNCE, 3'd1, DEB_INVALID_HI, OBD_OK, 8'h50, NOTIFY_NONE, 1'b1);
		add_checked(CMD_DEBOUNCE, 3'd4, DEB_INVALID, OBD_OK, 8'h50, NOTIFY_NONE, 1'b1);
		add_req(CMD_DEBOUNCE, 3'd2, DEB_PCTL_ABSENT, OBD_OK);
		add_checked(CMD_OBD, 3'd0, DEB_PRESENT, OBD_INVALID_HI, 8'h77, NOTIFY_NONE, 1'b1);
		add_checked(CMD_OBD, 3'd3, DEB_PRESENT, OBD_INVALID, 8'h50, NOTIFY_NONE, 1'b1);
		add_cfg(8'hFF, 8'h00, 1'b0);
		add_checked(CMD_OBD, 3'd7, DEB_PRESENT, OBD_CONFIRMED, 8'hD8, NOTIFY_UPDATED, 1'b0);
		add_req(CMD_OBD, 3'd6, DEB_PRESENT, OBD_PENDING2);
		add_req(CMD_OBD, 3'd5, DEB_PRESENT, OBD_OK);
		add_req(CMD_OBD, 3'd7, DEB_PRESENT, OBD_HISTORY_OFF);
		add_req(CMD_OBD, 3'd5, DEB_PRESENT, OBD_PENDING1);
		add_req(CMD_THRESHOLD, 3'd0, DEB_PRESENT, OBD_OK);
		add_req(CMD_THRESHOLD, 3'd3, DEB_INVALID_HI, OBD_OK);
		add_req(CMD_CLEAR, 3'd0, DEB_PRESENT, OBD_OK);
		add_cfg(8'h00, 8'h00, 1'b1);
		add_req(CMD_OBD, 3'd1, DEB_PRESENT, OBD_CONFIRMED);
		add_req(CMD_CLEAR, 3'd0, DEB_PRESENT, OBD_OK);
		add_req(CMD_POWER_RESET, 3'd6, DEB_FUGITIVE, OBD_HISTORY_OFF);
		add_req(CMD_POWER_RESET, 3'd4, DEB_INVALID_HI, OBD_INVALID_HI);
		add_req(CMD_CYCLE_START, 3'd0, DEB_PRESENT, OBD_OK);
		add_req(CMD_OBD_RESET, 3'd0, DEB_PRESENT, OBD_OK);
		add_cfg(8'h5A, 8'h81, 1'b0);
		add_req(CMD_OBD_RESET, 3'd0, DEB_PRESENT, OBD_OK);
		add_req(CMD_POWER_RESET, 3'd1, DEB_DEVALIDATION, OBD_HISTORY_OFF);
		add_cfg(8'hFF, 8'hFF, 1'b1);
		add_req(CMD_OBD_RESET, 3'd0, DEB_PRESENT, OBD_OK);
		add_req(CMD_RESET_ALL, 3'd0, DEB_PRESENT, OBD_OK);
		add_checked(CMD_DEBOUNCE, 3'd0, DEB_PRESENT, OBD_OK, 8'h77, NOTIFY_UPDATED, 1'b0);

		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (directed_plan[k]) begin
			if (directed_plan[k].is_cfg) begin
				drain(SETTLE_CYCLES);
				program_config(directed_plan[k].mil, directed_plan[k].obdm,
					directed_plan[k].clr);
			end else begin
				send_request(directed_plan[k].req, 1'b0);
				if (directed_plan[k].typed)
					expected_reports[expected_reports.size() - 1] = directed_plan[k].want;
			end
		end

		for (ph = 0; ph < PHASES; ph++) begin
			drain(SETTLE_CYCLES);
			case (ph)
				0: program_config(8'h00, 8'hFF, 1'b0);
				1: program_config(8'hFF, 8'h00, 1'b1);
				default: program_config(8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
					1'($urandom_range(0, 1)));
			endcase
			burst = (ph == 2);
			for (n = 0; n < PHASE_ITEMS; n++) begin
				// one full drain to let the block go idle mid-stream
				if (ph == 1 && n == 40)
					drain(0);
				pick = $urandom_range(0, 99);
				if (pick < 30)      req.command = CMD_DEBOUNCE;
				else if (pick < 55) req.command = CMD_OBD;
				else if (pick < 65) req.command = CMD_THRESHOLD;
				else if (pick < 73) req.command = CMD_CLEAR;
				else if (pick < 83) req.command = CMD_POWER_RESET;
				else if (pick < 90) req.command = CMD_CYCLE_START;
				else if (pick < 97) req.command = CMD_OBD_RESET;
				else                req.command = CMD_RESET_ALL;
				req.dtc_index      = 3'($urandom_range(0, 7));
				req.debounce_state = 3'($urandom_range(0, 7));
				req.obd_state      = 3'($urandom_range(0, 7));
				send_request(req, burst);
			end
		end

		drain(SETTLE_CYCLES);
		$display("ran %0d requests (%0d table sweeps) over %0d register settings",
			requests_sent, sweeps_sent, settings_used);
		$display("checked %0d results, %0d mismatches", reports_seen, mismatches);
		if (mismatches == 0)
			$display("*** PASSED ***");
		else
			$display("*** FAILED ***");
		$finish;
	end

	initial begin : result_sink
		int stall;
		wait (arst_n === 1'b1);
		@(posedge clk);
		out_ready <= 1'b1;
		forever begin
			@(posedge clk);
			if (out_valid && out_ready) begin
				check_report(out_data);
				reports_seen++;
				// one long hold so the block backs up into its input
				if (reports_seen == HOLD_AT)
					stall = HOLD_CYCLES;
				else if (reports_seen >= 200 && reports_seen < 280)
					stall = 0;
				else
					stall = $urandom_range(0, 9);
				if (stall > 0) begin
					out_ready <= 1'b0;
					repeat (stall) @(posedge clk);
					out_ready <= 1'b1;
				end
			end
		end
	end

	initial begin : watchdog
		#5_000_000;
		$display("timeout with %0d results outstanding", expected_reports.size());
		$display("*** FAILED ***");
		$finish;
	end

endmodule
